FILE: hdl/kbgc_pkg.sv
// Shared types, codes and helper functions for the keyed byte gamma cipher.
package kbgc_pkg;

  localparam logic [1:0] OP_KEY_LOAD = 2'd0;
  localparam logic [1:0] OP_DATA     = 2'd1;
  localparam logic [1:0] OP_RESTART  = 2'd2;

  localparam logic [1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [1:0] CFG_GROUP_COUNT = 2'd1;
  localparam logic [1:0] CFG_MSG_LENGTH  = 2'd2;

  localparam int unsigned SHIFT_BASE = 5;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic prep;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

  // floor(pz*11/255) + 5; x/255 for x < 65536 is (x + (x >> 8) + 1) >> 8
  function automatic logic [4:0] shift_amount(input logic [7:0] pz);
    logic [11:0] x;
    logic [12:0] t;
    begin
      x = 12'(pz) * 12'd11;
      t = 13'(x) + 13'(x >> 8) + 13'd1;
      shift_amount = 5'(t >> 8) + 5'(SHIFT_BASE);
    end
  endfunction

endpackage

FILE: hdl/kbgc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kbgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

FILE: hdl/kbgc_ctrl.sv
// Control state machine: divide, prepare, issue rounds, drain, hand off result.
module kbgc_ctrl #(
  parameter int MAX_KEY_WORDS = 32
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  input  logic [1:0]                                     in_operation,
  output logic                                           in_ready,
  input  logic [5:0]                                     group_count,
  input  kbgc_pkg::status_t                              status,
  output kbgc_pkg::cmd_t                                 cmd,
  output logic [(MAX_KEY_WORDS > 1 ? $clog2(MAX_KEY_WORDS) : 1)-1:0] rd_addr
);
  import kbgc_pkg::*;

  localparam int AW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int CW = $clog2(MAX_KEY_WORDS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [4:0]    div_cnt_r, div_cnt_nxt;
  logic [CW-1:0] rnd_cnt_r, rnd_cnt_nxt;
  logic [CW-1:0] rnd_inc;
  logic [CW-1:0] num_rounds;

  always_comb begin
    if (7'(group_count) > 7'(MAX_KEY_WORDS)) begin
      num_rounds = CW'(MAX_KEY_WORDS);
    end else begin
      num_rounds = CW'(group_count);
    end
  end

  assign rnd_inc  = rnd_cnt_r + 1'b1;
  assign rd_addr  = rnd_cnt_r[AW-1:0];
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    rnd_cnt_nxt = rnd_cnt_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_operation == OP_DATA) begin
            div_cnt_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == '1) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep    = 1'b1;
        rnd_cnt_nxt = '0;
        if (num_rounds == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.issue   = 1'b1;
        rnd_cnt_nxt = rnd_inc;
        if (rnd_inc == num_rounds) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
      rnd_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      rnd_cnt_r <= rnd_cnt_nxt;
    end
  end

endmodule

FILE: hdl/kbgc_dp.sv
// Datapath: key store, position, remainder unit, round pipeline, output register.
module kbgc_dp #(
  parameter int MAX_KEY_WORDS = 32
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  kbgc_pkg::cmd_t                                 cmd,
  output kbgc_pkg::status_t                              status,
  input  logic [(MAX_KEY_WORDS > 1 ? $clog2(MAX_KEY_WORDS) : 1)-1:0] rd_addr,
  input  logic [1:0]                                     in_operation,
  input  logic [4:0]                                     in_key_index,
  input  logic [31:0]                                    in_key_word,
  input  logic [7:0]                                     in_data_byte,
  input  logic                                           direction,
  input  logic [31:0]                                    message_length,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [7:0]                                     out_byte
);
  import kbgc_pkg::*;

  localparam int AW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

  logic [31:0] pos_r;
  logic [31:0] rem_r;
  logic [31:0] dvd_r;
  logic [4:0]  shift_r;
  logic [7:0]  byte_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        v0_r, v1_r, v2_r;
  logic [7:0]  a_r;
  logic [15:0] p_bd_r, p_da_r, p_ab_r, p_cd_r;
  logic [31:0] g_r;

  logic        key_wr;
  logic [31:0] key_rd;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [7:0]  pz;
  logic [16:0] t_sum;
  logic [31:0] g_nxt;
  logic [31:0] g_mix;
  logic [7:0]  k;

  assign key_wr = cmd.accept && (in_operation == OP_KEY_LOAD)
                  && (7'(in_key_index) < 7'(MAX_KEY_WORDS));

  kbgc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_KEY_WORDS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (AW'(in_key_index)),
    .wr_data (in_key_word),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  // restoring remainder, one bit per step
  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, pos_r};
  assign pz    = rem_r[7:0];

  assign t_sum = 17'(a_r) + 17'(p_bd_r) + 17'(p_da_r);
  assign g_nxt = 32'(25'(pz) * 25'(t_sum)) - 32'(p_ab_r) - 32'(p_cd_r);
  assign g_mix = 32'($signed(g_r) >>> shift_r) | (g_r << shift_r);
  assign k     = g_mix[7:0] + g_mix[31:24] - g_mix[23:16] + g_mix[15:8];

  assign status.pipe_busy = v0_r | v1_r | v2_r;
  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 32'd1;
      out_valid_r <= 1'b0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      if (cmd.accept && (in_operation == OP_RESTART)) begin
        pos_r <= 32'd1;
      end else if (cmd.out_load && (pos_r != '1)) begin
        pos_r <= pos_r + 32'd1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_operation == OP_DATA)) begin
      rem_r  <= '0;
      dvd_r  <= message_length;
      byte_r <= in_data_byte;
    end else begin
      if (cmd.div_step) begin
        rem_r <= diff[32] ? trial[31:0] : diff[31:0];
        dvd_r <= {dvd_r[30:0], 1'b0};
      end
      if (v2_r) begin
        byte_r <= direction ? (byte_r - k) : (byte_r + k);
      end
    end
    if (cmd.prep) begin
      shift_r <= shift_amount(pz);
    end
    if (v0_r) begin
      a_r    <= key_rd[31:24];
      p_bd_r <= key_rd[23:16] * key_rd[7:0];
      p_da_r <= key_rd[7:0] * key_rd[31:24];
      p_ab_r <= key_rd[31:24] * key_rd[23:16];
      p_cd_r <= key_rd[15:8] * key_rd[7:0];
    end
    if (v1_r) begin
      g_r <= g_nxt;
    end
    if (cmd.out_load) begin
      out_byte_r <= byte_r;
    end
  end

endmodule

FILE: hdl/keyed_byte_gamma_cipher.sv
// Data byte, n = min(group_count, key words): a bit-serial remainder of all 32 bits of
// message_length by position, a prep state, one key round per cycle through a three-stage
// round pipeline (skipped when n = 0), drain, then the output register.
// Next item accepted the cycle after the result is registered: one data byte at a time,
// held longer while an earlier result waits on out_ready. Key load and restart complete on acceptance.
// Synchronous active-low reset: direction 0, group_count 6, message_length 0, position 1.
module keyed_byte_gamma_cipher #(
  parameter int MAX_KEY_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import kbgc_pkg::*;

  localparam int AW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

  logic        direction_r;
  logic [5:0]  group_count_r;
  logic [31:0] msg_length_r;
  cmd_t        cmd;
  status_t     status;
  logic [AW-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= 1'b0;
      group_count_r <= 6'd6;
      msg_length_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIRECTION:   direction_r   <= cfg_data[0];
        CFG_GROUP_COUNT: group_count_r <= cfg_data[5:0];
        CFG_MSG_LENGTH:  msg_length_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  kbgc_ctrl #(
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .group_count  (group_count_r),
    .status       (status),
    .cmd          (cmd),
    .rd_addr      (rd_addr)
  );

  kbgc_dp #(
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .rd_addr        (rd_addr),
    .in_operation   (in_operation),
    .in_key_index   (in_key_index),
    .in_key_word    (in_key_word),
    .in_data_byte   (in_data_byte),
    .direction      (direction_r),
    .message_length (msg_length_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte)
  );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for keyed_byte_gamma_cipher: random and directed traffic vs. a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kbgc_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_KEYS        = 32;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 236;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_CYCLES     = 400;

  class cipher_scoreboard;
    logic        decrypt;
    logic [5:0]  rounds_cfg;
    logic [31:0] msg_length;
    logic [31:0] position;
    logic [31:0] key_slot [MAX_KEYS];
    logic [7:0]  expected_bytes [$];
    int          op_seen [4];
    int          cfg_writes;
    int          checked;
    int          errors;

    function new();
      decrypt    = 1'b0;
      rounds_cfg = 6'd6;
      msg_length = '0;
      position   = 32'd1;
      foreach (key_slot[i]) key_slot[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      cfg_writes = 0;
      checked    = 0;
      errors     = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      cfg_writes++;
      case (idx)
        CFG_DIRECTION:   decrypt = value[0];
        CFG_GROUP_COUNT: rounds_cfg = value[5:0];
        CFG_MSG_LENGTH:  msg_length = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] gamma_byte(logic [31:0] word, logic [7:0] pz);
      logic [31:0]        a, b, c, d, g, sr, sl;
      logic signed [31:0] gs;
      int unsigned        s;
      a  = {24'd0, word[31:24]};
      b  = {24'd0, word[23:16]};
      c  = {24'd0, word[15:8]};
      d  = {24'd0, word[7:0]};
      g  = {24'd0, pz} * (a + b * d + d * a) - a * b - c * d;
      s  = (int'(pz) * 11) / 255 + 5;
      gs = g;
      sr = gs >>> s;
      sl = g << s;
      g  = sr | sl;
      gamma_byte = g[7:0] + g[31:24] - g[23:16] + g[15:8];
    endfunction

    function void note_transaction(logic [1:0] op, logic [4:0] idx, logic [31:0] word,
                                   logic [7:0] data);
      int         rounds;
      int         i;
      logic [7:0] pz;
      logic [7:0] k;
      logic [7:0] value;
      op_seen[op]++;
      case (op)
        OP_KEY_LOAD: if (idx < MAX_KEYS) key_slot[idx] = word;
        OP_RESTART:  position = 32'd1;
        OP_DATA: begin
          rounds = (rounds_cfg > MAX_KEYS) ? MAX_KEYS : rounds_cfg;
          pz     = 8'(msg_length % position);
          value  = data;
          for (i = 0; i < rounds; i++) begin
            k     = gamma_byte(key_slot[i], pz);
            value = decrypt ? value - k : value + k;
          end
          if (position != 32'hFFFF_FFFF) position++;
          expected_bytes.push_back(value);
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("out_byte %02h arrived with nothing pending", got);
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("out_byte mismatch on byte %0d: expected %02h, got %02h", checked, want, got);
      end
    endfunction

    function void close_out();
      if (expected_bytes.size() != 0) begin
        errors++;
        $display("%0d expected bytes never came out", expected_bytes.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [4:0]  in_key_index;
  logic [31:0] in_key_word;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cipher_scoreboard sb;
  logic [MAX_KEYS-1:0] slot_loaded;
  int                  rounds_now;
  int                  restart_pct;
  bit                  no_idle;
  bit                  hold_request;

  keyed_byte_gamma_cipher #(.MAX_KEY_WORDS(MAX_KEYS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key_index (in_key_index),
    .in_key_word  (in_key_word),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_transaction(in_operation, in_key_index, in_key_word, in_data_byte);
      if (out_valid && out_ready) sb.check_byte(out_byte);
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("[keyed_byte_gamma_cipher] ERROR");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                           input logic [31:0] word, input logic [7:0] data);
    int gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_index <= idx;
    in_key_word  <= word;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    if (!no_idle && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int first_missing_slot();
    for (int i = 0; i < rounds_now; i++)
      if (!slot_loaded[i]) return i;
    return -1;
  endfunction

  task automatic set_phase(input int ph);
    logic        dir;
    logic [5:0]  gc;
    logic [31:0] len;
    dir = 1'(ph % 2);
    case (ph)
      1: begin gc = 6'd1;  len = 32'hFFFF_FFFF; end
      2: begin gc = 6'd32; len = $urandom; end
      3: begin gc = 6'd0;  len = $urandom; end
      4: begin gc = 6'd63; len = $urandom; end
      5: begin gc = 6'd33; len = $urandom_range(300); end
      6: begin gc = 6'($urandom_range(1, 32)); len = $urandom; end
      default: begin gc = 6'd6; len = '0; end
    endcase
    write_cfg(CFG_DIRECTION, {31'd0, dir});
    write_cfg(CFG_GROUP_COUNT, {26'd0, gc});
    write_cfg(CFG_MSG_LENGTH, len);
    if (ph == 4) write_cfg(CFG_UNUSED, $urandom);
    rounds_now = (gc > MAX_KEYS) ? MAX_KEYS : gc;
  endtask

  task automatic directed_items();
    logic [31:0] words [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h0102_0304, 32'hFF00_FF00};
    for (int i = 0; i < 6; i++) begin
      slot_loaded[i] = 1'b1;
      send_item(OP_KEY_LOAD, 5'(i), words[i], 8'($urandom));
    end
    send_item(OP_DATA, 5'd0, 32'd0, 8'h00);
    send_item(OP_DATA, 5'd31, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_DATA, 5'd0, 32'd0, 8'h80);
    send_item(OP_DATA, 5'd0, 32'd0, 8'h7F);
    // unused opcode must leave slot 0 alone
    send_item(OP_UNUSED, 5'd0, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_DATA, 5'd0, 32'd0, 8'h55);
    send_item(OP_RESTART, 5'd0, 32'd0, 8'h00);
    send_item(OP_DATA, 5'd0, 32'd0, 8'hAA);
    slot_loaded[31] = 1'b1;
    send_item(OP_KEY_LOAD, 5'd31, $urandom, 8'($urandom));
    send_item(OP_DATA, 5'd0, 32'd0, 8'h01);
  endtask

  task automatic random_item();
    int          pick;
    int          missing;
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [31:0] word;
    pick = $urandom_range(99);
    idx  = 5'($urandom);
    case ($urandom_range(7))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    if (pick < 68) op = OP_DATA;
    else if (pick < 84) op = OP_KEY_LOAD;
    else if (pick < 95) op = ($urandom_range(10) < restart_pct) ? OP_RESTART : OP_DATA;
    else op = OP_UNUSED;
    if (op == OP_DATA) begin
      missing = first_missing_slot();
      if (missing >= 0) begin
        op  = OP_KEY_LOAD;
        idx = 5'(missing);
      end
    end
    if (op == OP_KEY_LOAD) slot_loaded[idx] = 1'b1;
    send_item(op, idx, word, 8'($urandom));
  endtask

  initial begin : stimulus
    int ph;
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_KEY_LOAD;
    in_key_index <= '0;
    in_key_word  <= '0;
    in_data_byte <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_DIRECTION;
    cfg_data     <= '0;
    slot_loaded  = '0;
    rounds_now   = 6;
    restart_pct  = 11;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        set_phase(ph);
      end
      no_idle     = (ph == 5);
      // long restart-free runs let the position pass 255 so every shift is reached
      restart_pct = (ph >= 2 && ph <= 4) ? 0 : 11;
      if (ph == 0) directed_items();
      if (ph == 1) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) random_item();
    end
    wait_idle();
    sb.close_out();
    $display("covered %0d key loads, %0d data bytes, %0d restarts, %0d unused-op transactions",
             sb.op_seen[OP_KEY_LOAD], sb.op_seen[OP_DATA], sb.op_seen[OP_RESTART],
             sb.op_seen[OP_UNUSED]);
    $display("%0d bytes checked over %0d register writes, both directions, 0..63 key words",
             sb.checked, sb.cfg_writes);
    if (sb.errors == 0) begin
      $display("[keyed_byte_gamma_cipher] OK");
    end else begin
      $display("%0d errors", sb.errors);
      $display("[keyed_byte_gamma_cipher] ERROR");
    end
    $finish;
  end

endmodule
